### hdl/b64e_pkg.sv
// Package for the base64 stream encoder: character word type, group phase
// codes and the 6-bit to ASCII alphabet map. No dependencies.
package b64e_pkg;

   localparam int GROUP_W = 6;
   localparam int CHAR_W  = 7;
   localparam int LEFT_W  = 4;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [CHAR_W-1:0] b64_char;
      logic              run_last;
      logic              message_end;
   } char_word_type;

   function automatic logic [CHAR_W-1:0] b64_map(input logic [GROUP_W-1:0] grp);
      logic [CHAR_W-1:0] g;
      logic [CHAR_W-1:0] res;
      g = {1'b0, grp};
      case (grp) inside
         [6'd0:6'd25]:  res = CHAR_W'(7'd65 + g);
         [6'd26:6'd51]: res = CHAR_W'(7'd97 + g - 7'd26);
         [6'd52:6'd61]: res = CHAR_W'(7'd48 + g - 7'd52);
         6'd62:         res = 7'd43;
         default:       res = 7'd47;
      endcase
      return res;
   endfunction

endpackage

### hdl/b64e_if.sv
// Valid/ready channel interfaces for the base64 stream encoder.
// Depends on b64e_pkg for field widths.
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [b64e_pkg::CHAR_W-1:0]   b64_char;
   logic                          run_last;
   logic                          message_end;

   modport source (output valid, output b64_char, output run_last, output message_end,
                   input ready);
   modport sink   (input valid, input b64_char, input run_last, input message_end,
                   output ready);
endinterface

### hdl/base64_encode_stream_nopad.sv
// Base64 stream encoder (standard alphabet, no padding), top level.
// Depends on b64e_pkg and the channel interfaces in b64e_if.sv.
//
// Bytes enter on req_chan, MSB first, and leave as base64 ASCII characters on
// rsp_chan, one character per cycle while rsp_chan.ready is high. A byte
// gives one character, or two when it closes a three-byte group or carries
// final_byte; the final byte flushes any partial group zero filled and tags
// that character with message_end. A byte is taken every cycle while each
// gives one character and the output does not stall; a byte that gives two
// holds off the next until its first character leaves the slot register for
// the output register. run_last marks the last character from each byte.
// State returns to the start of a group after a final byte.
module base64_encode_stream_nopad (
   input  logic            clock,
   input  logic            reset,
   b64e_req_if.sink        req_chan,
   b64e_rsp_if.source      rsp_chan
);
   import b64e_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [LEFT_W-1:0]   left_ff, left_in;
   char_word_type       slot_ff [2];
   char_word_type       slot_in [2];
   logic [1:0]          cnt_ff, cnt_in;
   logic                out_valid_ff, out_valid_in;
   char_word_type       out_ff, out_in;

   logic                out_free;
   logic                move;
   logic                accept;
   char_word_type       new0, new1;
   logic [1:0]          new_cnt;
   logic [7:0]          b;
   logic                fin;

   always_comb begin
      b   = req_chan.data_byte;
      fin = req_chan.final_byte;
      new0     = '0;
      new1     = '0;
      new_cnt  = 2'd1;
      phase_in = phase_ff;
      left_in  = left_ff;
      case (phase_ff)
         PH_SECOND: begin
            new0.b64_char = b64_map({left_ff[1:0], b[7:4]});
            new0.run_last = !fin;
            new1.b64_char = b64_map({b[3:0], 2'b00});
            new1.run_last = 1'b1;
            new1.message_end = 1'b1;
            new_cnt  = fin ? 2'd2 : 2'd1;
            phase_in = PH_THIRD;
            left_in  = b[3:0];
         end
         PH_THIRD: begin
            new0.b64_char = b64_map({left_ff[3:0], b[7:6]});
            new1.b64_char = b64_map(b[5:0]);
            new1.run_last = 1'b1;
            new1.message_end = fin;
            new_cnt  = 2'd2;
            phase_in = PH_FIRST;
            left_in  = '0;
         end
         default: begin
            new0.b64_char = b64_map(b[7:2]);
            new0.run_last = !fin;
            new1.b64_char = b64_map({b[1:0], 4'b0000});
            new1.run_last = 1'b1;
            new1.message_end = 1'b1;
            new_cnt  = fin ? 2'd2 : 2'd1;
            phase_in = PH_SECOND;
            left_in  = {2'b00, b[1:0]};
         end
      endcase
      if (fin) begin
         phase_in = PH_FIRST;
         left_in  = '0;
      end
   end

   always_comb begin
      out_free       = !out_valid_ff || rsp_chan.ready;
      move           = out_free && (cnt_ff != 2'd0);
      req_chan.ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && out_free);
      accept         = req_chan.valid && req_chan.ready;

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      slot_in[0]   = slot_ff[0];
      slot_in[1]   = slot_ff[1];
      cnt_in       = cnt_ff;

      if (move) begin
         out_valid_in = 1'b1;
         out_in       = slot_ff[0];
         slot_in[0]   = slot_ff[1];
         cnt_in       = cnt_ff - 2'd1;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end

      if (accept) begin
         slot_in[0] = new0;
         slot_in[1] = new1;
         cnt_in     = new_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         left_ff      <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            left_ff  <= left_in;
         end
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      out_ff     <= out_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.b64_char    = out_ff.b64_char;
   assign rsp_chan.run_last    = out_ff.run_last;
   assign rsp_chan.message_end = out_ff.message_end;

endmodule

### hdl/b64e_checker.sv
// Port-level checks for the base64 stream encoder, bound to its top level.
// Depends on b64e_pkg and base64_encode_stream_nopad.
module b64e_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [b64e_pkg::CHAR_W-1:0] b64_char,
   input logic                        run_last,
   input logic                        message_end
);
   import b64e_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output word valid after reset");

   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(b64_char)
                                 && $stable(run_last) && $stable(message_end))
      else $error("stalled output word changed");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && message_end |-> run_last)
      else $error("message end without run end");

   a_alphabet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((b64_char >= 7'd65) && (b64_char <= 7'd90))
                 || ((b64_char >= 7'd97) && (b64_char <= 7'd122))
                 || ((b64_char >= 7'd48) && (b64_char <= 7'd57))
                 || (b64_char == 7'd43) || (b64_char == 7'd47))
      else $error("character outside base64 alphabet");

endmodule

bind base64_encode_stream_nopad b64e_checker u_b64e_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .b64_char    (rsp_chan.b64_char),
   .run_last    (rsp_chan.run_last),
   .message_end (rsp_chan.message_end)
);
